[hdl/tfrtt_pkg.sv]
// Package for the TCP flow tracker: counter width, flag bits, action codes,
// configuration register indexes and the flow state record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfrtt_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
   localparam logic [7:0]  NONHTTP_LIMIT_RESET = 8'd5;
   localparam logic [7:0]  RST_MIN_RESET       = 8'd4;

   localparam int FLAG_FIN = 0;
   localparam int FLAG_SYN = 1;
   localparam int FLAG_RST = 2;
   localparam int FLAG_ACK = 4;
   localparam logic [7:0] FLAGS_BARE_SYN = 8'h02;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NONHTTP_LIMIT = 2'd0,
      CSR_RST_MIN       = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_COUNT   = 2'd0,
      ACT_STORE   = 2'd1,
      ACT_DISCARD = 2'd2,
      ACT_CLOSE   = 2'd3
   } action_type;

   typedef struct packed {
      logic        from_client;
      logic [7:0]  flag_bits;
      logic [15:0] payload_len;
      logic        has_http;
      logic [31:0] cap_sec;
      logic [19:0] cap_subsec;
      logic [31:0] now_sec;
      logic [19:0] now_usec;
   } pkt_type;

   typedef struct packed {
      logic                   http_flag;
      logic [COUNT_WIDTH-1:0] client_pkts;
      logic [COUNT_WIDTH-1:0] server_pkts;
      logic [COUNT_WIDTH-1:0] client_bytes;
      logic [COUNT_WIDTH-1:0] server_bytes;
      logic [COUNT_WIDTH-1:0] client_stored;
      logic [COUNT_WIDTH-1:0] server_stored;
      logic [31:0]            syn_sec;
      logic [19:0]            syn_subsec;
      logic [31:0]            round_trip;
      logic [31:0]            act_sec;
      logic [19:0]            act_usec;
   } flow_type;

   function automatic flow_type count_pkt(flow_type f, pkt_type p);
      flow_type r;
      r = f;
      if (p.from_client) begin
         r.client_pkts  = f.client_pkts + COUNT_WIDTH'(1);
         r.client_bytes = f.client_bytes + COUNT_WIDTH'(p.payload_len);
      end else begin
         r.server_pkts  = f.server_pkts + COUNT_WIDTH'(1);
         r.server_bytes = f.server_bytes + COUNT_WIDTH'(p.payload_len);
      end
      r.act_sec  = p.now_sec;
      r.act_usec = p.now_usec;
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/tcp_flow_tracker_rtt.sv]
// Top level of the TCP flow tracker with handshake round-trip measurement.
// Depends on tfrtt_pkg for types, codes and the counting function.
//
//   channel | direction | handshake           | contents
//   req_    | in        | req_valid/req_stall | one packet descriptor per word
//   rsp_    | out       | rsp_valid/rsp_stall | action and flow counts per word
//   csr_    | in        | csr_we              | nonhttp_limit, rst_min_packets
//
// A word is taken into an input register; once the result register is free, the
// flow state and the result register are updated together from it, so one word
// per cycle is sustained while rsp_stall is low. The path from input to result
// register holds the 32 x 32 bit RTT multiply and the adders.
// Synchronous active-high reset clears the flow state and loads the register
// defaults. A stalled result holds the result register and any word already in
// the input register; req_stall rises while a word waits behind it.
`timescale 1ns / 1ps
`default_nettype none

module tcp_flow_tracker_rtt (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [tfrtt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tfrtt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_from_client,
   input  wire logic [7:0]                        req_flag_bits,
   input  wire logic [15:0]                       req_payload_len,
   input  wire logic                              req_has_http,
   input  wire logic [31:0]                       req_cap_sec,
   input  wire logic [19:0]                       req_cap_subsec,
   input  wire logic [31:0]                       req_now_sec,
   input  wire logic [19:0]                       req_now_usec,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_action,
   output logic [31:0]                            rsp_client_packets,
   output logic [31:0]                            rsp_server_packets,
   output logic [31:0]                            rsp_client_bytes,
   output logic [31:0]                            rsp_server_bytes,
   output logic [31:0]                            rsp_stored_client,
   output logic [31:0]                            rsp_stored_server,
   output logic [31:0]                            rsp_rtt_us,
   output logic                                   rsp_http_seen,
   output logic [31:0]                            rsp_last_sec,
   output logic [19:0]                            rsp_last_usec
);

   localparam int CW = tfrtt_pkg::COUNT_WIDTH;

   logic [7:0]           limit_ff, limit_in;
   logic [7:0]           rst_min_ff, rst_min_in;
   logic                 pkt_valid_ff, pkt_valid_in;
   tfrtt_pkg::pkt_type   pkt_ff, pkt_in;
   tfrtt_pkg::flow_type  flow_ff, flow_in;
   logic                 out_valid_ff, out_valid_in;
   tfrtt_pkg::flow_type  out_ff, out_in;
   tfrtt_pkg::action_type act_ff, act_in;

   logic                 req_take;
   logic                 out_free;
   logic                 advance;
   tfrtt_pkg::flow_type  upd;
   tfrtt_pkg::action_type act;
   logic                 clear_after;
   logic                 limit_hit;
   logic                 hs_ack;
   logic                 syn_case;
   logic [31:0]          sec_diff;

   // configuration decode
   always_comb begin
      limit_in   = limit_ff;
      rst_min_in = rst_min_ff;
      if (csr_we) begin
         unique case (csr_index)
            tfrtt_pkg::CSR_NONHTTP_LIMIT: limit_in   = csr_wdata;
            tfrtt_pkg::CSR_RST_MIN:       rst_min_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = pkt_valid_ff && out_free;
   assign req_stall = pkt_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign pkt_valid_in = req_take || (pkt_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_comb begin
      pkt_in = pkt_ff;
      if (req_take) begin
         pkt_in.from_client = req_from_client;
         pkt_in.flag_bits   = req_flag_bits;
         pkt_in.payload_len = req_payload_len;
         pkt_in.has_http    = req_has_http;
         pkt_in.cap_sec     = req_cap_sec;
         pkt_in.cap_subsec  = req_cap_subsec;
         pkt_in.now_sec     = req_now_sec;
         pkt_in.now_usec    = req_now_usec;
      end
   end

   // per-packet decision
   assign limit_hit = !flow_ff.http_flag && (flow_ff.client_pkts >= CW'(limit_ff));
   assign hs_ack    = pkt_ff.from_client && (flow_ff.client_pkts == CW'(1))
                      && pkt_ff.flag_bits[tfrtt_pkg::FLAG_ACK];
   assign syn_case  = pkt_ff.from_client && ((flow_ff.client_pkts == '0)
                      || (pkt_ff.flag_bits == tfrtt_pkg::FLAGS_BARE_SYN));
   assign sec_diff  = pkt_ff.cap_sec - flow_ff.syn_sec;

   always_comb begin
      upd         = flow_ff;
      act         = tfrtt_pkg::ACT_COUNT;
      clear_after = 1'b0;
      if (limit_hit) begin
         act         = tfrtt_pkg::ACT_DISCARD;
         clear_after = 1'b1;
      end else if (pkt_ff.flag_bits[tfrtt_pkg::FLAG_RST]) begin
         clear_after = 1'b1;
         if (flow_ff.client_pkts < CW'(rst_min_ff)) begin
            act = tfrtt_pkg::ACT_DISCARD;
         end else begin
            upd = tfrtt_pkg::count_pkt(flow_ff, pkt_ff);
            act = tfrtt_pkg::ACT_CLOSE;
         end
      end else if (hs_ack) begin
         upd            = tfrtt_pkg::count_pkt(flow_ff, pkt_ff);
         upd.round_trip = 32'(sec_diff * tfrtt_pkg::USEC_PER_SEC)
                          + (32'(pkt_ff.cap_subsec) - 32'(flow_ff.syn_subsec));
      end else if (pkt_ff.flag_bits[tfrtt_pkg::FLAG_FIN]) begin
         upd         = tfrtt_pkg::count_pkt(flow_ff, pkt_ff);
         act         = tfrtt_pkg::ACT_CLOSE;
         clear_after = 1'b1;
      end else begin
         if (syn_case) begin
            if (flow_ff.client_pkts != '0) begin
               upd = '0;
            end
            upd.syn_sec    = pkt_ff.cap_sec;
            upd.syn_subsec = pkt_ff.cap_subsec;
         end else if (pkt_ff.has_http) begin
            upd.http_flag = 1'b1;
            act           = tfrtt_pkg::ACT_STORE;
            if (pkt_ff.from_client) begin
               upd.client_stored = flow_ff.client_stored + CW'(1);
            end else begin
               upd.server_stored = flow_ff.server_stored + CW'(1);
            end
         end
         upd = tfrtt_pkg::count_pkt(upd, pkt_ff);
      end
   end

   always_comb begin
      flow_in = flow_ff;
      out_in  = out_ff;
      act_in  = act_ff;
      if (advance) begin
         flow_in = clear_after ? '0 : upd;
         out_in  = upd;
         act_in  = act;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= tfrtt_pkg::NONHTTP_LIMIT_RESET;
         rst_min_ff   <= tfrtt_pkg::RST_MIN_RESET;
         pkt_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         flow_ff      <= '0;
      end else begin
         limit_ff     <= limit_in;
         rst_min_ff   <= rst_min_in;
         pkt_valid_ff <= pkt_valid_in;
         out_valid_ff <= out_valid_in;
         flow_ff      <= flow_in;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff <= pkt_in;
      out_ff <= out_in;
      act_ff <= act_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_action         = act_ff;
   assign rsp_client_packets = 32'(out_ff.client_pkts);
   assign rsp_server_packets = 32'(out_ff.server_pkts);
   assign rsp_client_bytes   = 32'(out_ff.client_bytes);
   assign rsp_server_bytes   = 32'(out_ff.server_bytes);
   assign rsp_stored_client  = 32'(out_ff.client_stored);
   assign rsp_stored_server  = 32'(out_ff.server_stored);
   assign rsp_rtt_us         = out_ff.round_trip;
   assign rsp_http_seen      = out_ff.http_flag;
   assign rsp_last_sec       = out_ff.act_sec;
   assign rsp_last_usec      = out_ff.act_usec;

endmodule

`default_nettype wire
